### hw/rtl/olte_pkg.sv
// ----------------------------------------------------------------------------
// olte_pkg : shared types for the ordered list table engine
// Request kinds, status codes, controller states and the command / status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package olte_pkg;

    // Default number of list slots
    localparam int OLT_DEPTH = 16;

    // Width of one list entry
    localparam int OLT_DATA_W = 64;

    // Request kinds
    typedef enum logic [3:0] {
        REQ_INS_HEAD = 4'd0,
        REQ_INS_TAIL = 4'd1,
        REQ_INS_AT   = 4'd2,
        REQ_RM_HEAD  = 4'd3,
        REQ_RM_TAIL  = 4'd4,
        REQ_RM_AT    = 4'd5,
        REQ_RM_FIRST = 4'd6,
        REQ_RM_ALL   = 4'd7,
        REQ_FIND     = 4'd8,
        REQ_GET      = 4'd9
    } req_kind_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_DECIDE = 2'd1,
        S_SCAN   = 2'd2,
        S_OUT    = 2'd3
    } ctrl_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;         // latch request, clear result
        logic exec;         // request kinds that need no scan
        logic scan_next;    // examine one entry, compact if not matching
        logic drop_hit;     // drop the entry under the scan index
        logic compact_end;  // count takes the compaction write pointer
    } olte_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        req_kind_t kind;
        logic      match;
        logic      scan_done;
    } olte_stat_t;

endpackage

### hw/rtl/olte_ctrl.sv
// ----------------------------------------------------------------------------
// olte_ctrl : request sequencer
// Takes a request, issues one single-cycle command or walks the scan loop for
// value searches, then raises the result strobe for one cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module olte_ctrl
    import olte_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  olte_stat_t stat,
    output olte_cmd_t  cmd,
    output logic       busy,
    output logic       done
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (stat.kind inside {REQ_RM_FIRST, REQ_RM_ALL, REQ_FIND})
                begin
                    state_next = S_SCAN;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_SCAN:
            begin
                if (stat.scan_done)
                begin
                    state_next = S_OUT;
                end
                else if (stat.match && stat.kind != REQ_RM_ALL)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        done = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            S_DECIDE:
            begin
                cmd.exec = !(stat.kind inside {REQ_RM_FIRST, REQ_RM_ALL, REQ_FIND});
            end
            S_SCAN:
            begin
                if (stat.scan_done)
                begin
                    cmd.compact_end = (stat.kind == REQ_RM_ALL);
                end
                else if (stat.match && stat.kind == REQ_RM_FIRST)
                begin
                    cmd.drop_hit = 1'b1;
                end
                else
                begin
                    cmd.scan_next = 1'b1;
                end
            end
            S_OUT:
            begin
                done = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    // Checks
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one cycle");

    a_accept_decide: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (state_reg == S_DECIDE))
        else $error("accepted request did not reach decode");

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.exec, cmd.scan_next, cmd.drop_hit, cmd.compact_end}))
        else $error("more than one datapath command at once");

endmodule

### hw/rtl/olte_datapath.sv
// ----------------------------------------------------------------------------
// olte_datapath : list cells, count and result registers
// Entries live in register cells that shift by one slot for insert and drop;
// value removal walks a read index and a compaction write index.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module olte_datapath
    import olte_pkg::*;
#(
    parameter int DEPTH = OLT_DEPTH,
    localparam int CNT_W = $clog2(DEPTH + 1),
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  olte_cmd_t             cmd,
    output olte_stat_t            stat,
    input  logic [3:0]            req_type,
    input  logic [CNT_W-1:0]      position,
    input  logic [OLT_DATA_W-1:0] item_value,
    output logic [1:0]            status,
    output logic                  hit,
    output logic [OLT_DATA_W-1:0] read_value,
    output logic [CNT_W-1:0]      entry_count
);

    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

    // Request latch
    req_kind_t             kind_reg;
    logic [CNT_W-1:0]      pos_reg;
    logic [OLT_DATA_W-1:0] val_reg;

    // Scan read index and compaction write index
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] wr_reg, wr_next;

    // List state
    logic [OLT_DATA_W-1:0] entries_reg [DEPTH];
    logic [OLT_DATA_W-1:0] entries_next [DEPTH];
    logic [CNT_W-1:0]      count_reg, count_next;

    // Result
    status_t               status_reg, status_next;
    logic                  hit_reg, hit_next;
    logic [OLT_DATA_W-1:0] rd_reg, rd_next;

    // Cell control
    logic                  ins_en;
    logic [CNT_W-1:0]      ins_p;
    logic                  drop_en;
    logic [CNT_W-1:0]      drop_p;
    logic                  copy_en;
    logic [OLT_DATA_W-1:0] scan_rd;
    logic                  match;

    assign scan_rd = entries_reg[idx_reg[IDX_W-1:0]];
    assign match   = (scan_rd == val_reg);

    assign stat.kind      = kind_reg;
    assign stat.match     = match;
    assign stat.scan_done = (idx_reg >= count_reg);

    // Request decode and result
    always_comb
    begin
        ins_en      = 1'b0;
        ins_p       = '0;
        drop_en     = 1'b0;
        drop_p      = '0;
        copy_en     = 1'b0;
        idx_next    = idx_reg;
        wr_next     = wr_reg;
        count_next  = count_reg;
        status_next = status_reg;
        hit_next    = hit_reg;
        rd_next     = rd_reg;

        if (cmd.load)
        begin
            status_next = ST_OK;
            hit_next    = 1'b0;
            rd_next     = '0;
            wr_next     = '0;
            idx_next    = (req_type == REQ_GET) ? position : '0;
        end

        if (cmd.exec)
        begin
            unique case (kind_reg) inside
                REQ_INS_HEAD, REQ_INS_TAIL, REQ_INS_AT:
                begin
                    if (kind_reg == REQ_INS_HEAD)
                    begin
                        ins_p = '0;
                    end
                    else if (kind_reg == REQ_INS_TAIL)
                    begin
                        ins_p = count_reg;
                    end
                    else
                    begin
                        ins_p = pos_reg;
                    end
                    if (ins_p > count_reg)
                    begin
                        status_next = ST_RANGE;
                    end
                    else if (count_reg >= DEPTH_C)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        ins_en     = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
                REQ_RM_HEAD, REQ_RM_TAIL:
                begin
                    if (count_reg == '0)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        drop_en    = 1'b1;
                        drop_p     = (kind_reg == REQ_RM_HEAD) ? '0 : count_reg - 1'b1;
                        count_next = count_reg - 1'b1;
                    end
                end
                REQ_RM_AT:
                begin
                    if (pos_reg >= count_reg)
                    begin
                        status_next = ST_RANGE;
                    end
                    else
                    begin
                        drop_en    = 1'b1;
                        drop_p     = pos_reg;
                        count_next = count_reg - 1'b1;
                    end
                end
                REQ_GET:
                begin
                    if (pos_reg >= count_reg)
                    begin
                        status_next = ST_RANGE;
                    end
                    else
                    begin
                        rd_next = scan_rd;
                    end
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase
        end

        // scan step: matching entries are skipped, the rest close up
        if (cmd.scan_next)
        begin
            idx_next = idx_reg + 1'b1;
            if (match)
            begin
                hit_next = 1'b1;
            end
            else
            begin
                copy_en = 1'b1;
                wr_next = wr_reg + 1'b1;
            end
        end

        if (cmd.drop_hit)
        begin
            drop_en    = 1'b1;
            drop_p     = idx_reg;
            hit_next   = 1'b1;
            count_next = count_reg - 1'b1;
        end

        if (cmd.compact_end)
        begin
            count_next = wr_reg;
        end
    end

    // Cell moves
    always_comb
    begin
        for (int j = 0; j < DEPTH; j++)
        begin
            entries_next[j] = entries_reg[j];
        end
        if (ins_en)
        begin
            for (int j = 1; j < DEPTH; j++)
            begin
                if (CNT_W'(j) > ins_p)
                begin
                    entries_next[j] = entries_reg[j-1];
                end
            end
            entries_next[ins_p[IDX_W-1:0]] = val_reg;
        end
        if (drop_en)
        begin
            for (int j = 0; j < DEPTH - 1; j++)
            begin
                if (CNT_W'(j) >= drop_p)
                begin
                    entries_next[j] = entries_reg[j+1];
                end
            end
        end
        if (copy_en)
        begin
            entries_next[wr_reg[IDX_W-1:0]] = scan_rd;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            idx_reg    <= '0;
            wr_reg     <= '0;
            status_reg <= ST_OK;
            hit_reg    <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            idx_reg    <= idx_next;
            wr_reg     <= wr_next;
            status_reg <= status_next;
            hit_reg    <= hit_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= req_kind_t'(req_type);
            pos_reg  <= position;
            val_reg  <= item_value;
        end
        rd_reg <= rd_next;
        for (int j = 0; j < DEPTH; j++)
        begin
            entries_reg[j] <= entries_next[j];
        end
    end

    assign status      = status_reg;
    assign hit         = hit_reg;
    assign read_value  = rd_reg;
    assign entry_count = count_reg;

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("entry count above depth");

    a_wr_behind: assert property (@(posedge clk) disable iff (!rst_n)
        wr_reg <= idx_reg)
        else $error("compaction write index passed read index");

    a_hit_ok: assert property (@(posedge clk) disable iff (!rst_n)
        hit_reg |-> (status_reg == ST_OK))
        else $error("hit with error status");

    a_count_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
            $past(cmd.exec || cmd.drop_hit || cmd.compact_end))
        else $error("count changed without a command");

endmodule

### hw/rtl/ordered_list_table_engine.sv
// ----------------------------------------------------------------------------
// ordered_list_table_engine : bounded ordered list with insert and remove
// Holds up to DEPTH signed 64-bit entries in order and serves one request at
// a time, returning status, hit, read value and the new count.
// ----------------------------------------------------------------------------
// Usage
//   Request channel: a request is taken at a rising edge with start high and
//   busy low; req_type, position and item_value are sampled at that edge.
//   busy stays high until the result has been delivered.
//   Result channel: done is high for exactly one cycle with status, hit,
//   read_value, entry_count and is_empty; the receiver cannot hold it off.
//   Sequence: insert, remove by head, tail or position, get and unused codes
//   pass through decode and then give done. Find and remove-first scan from
//   slot 0 up to the first match (to the end of the list when none), then
//   give done; remove-all scans every entry and then sets the new count. The
//   scan examines one entry per cycle through a single compare on the entry
//   read port. A new request is taken only once done has been given and the
//   engine is back in idle with busy low.
//   Reset: asynchronous, active low; the list becomes empty. Entry contents
//   are not cleared and are never read before being written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ordered_list_table_engine
    import olte_pkg::*;
#(
    parameter int DEPTH = OLT_DEPTH,
    localparam int CNT_W = $clog2(DEPTH + 1)
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [3:0]                   req_type,
    input  logic [CNT_W-1:0]             position,
    input  logic signed [OLT_DATA_W-1:0] item_value,
    output logic                         done,
    output logic [1:0]                   status,
    output logic                         hit,
    output logic signed [OLT_DATA_W-1:0] read_value,
    output logic [CNT_W-1:0]             entry_count,
    output logic                         is_empty
);

    olte_cmd_t             cmd;
    olte_stat_t            stat;
    logic [OLT_DATA_W-1:0] rd_value;
    logic [CNT_W-1:0]      count;

    // Sequencer
    olte_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // List storage and result
    olte_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .req_type    (req_type),
        .position    (position),
        .item_value  (item_value),
        .status      (status),
        .hit         (hit),
        .read_value  (rd_value),
        .entry_count (count)
    );

    assign read_value  = rd_value;
    assign entry_count = count;
    assign is_empty    = (count == '0);

endmodule
